/* rtl/cbpa_pkg.sv */
`default_nettype none
package cbpa_pkg;

	localparam int NUM_BLOCKS_DEF = 64;
	localparam int BLOCK_BYTES = 64;
	localparam int MAX_REQUEST = 4096;

	localparam int OP_W = 2;
	localparam int SIZE_W = 13;
	localparam int OFF_W = 13;
	localparam int ST_W = 3;
	localparam int ROFF_W = 12;
	localparam int CNT_W = 32;
	localparam int FREE_W = 7;
	// wide enough for size plus block bytes minus one
	localparam int VAL_W = 14;

	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE = 2'd1;
	localparam logic [OP_W-1:0] OP_RESIZE = 2'd2;

	localparam logic [ST_W-1:0] ST_OK = 3'd0;
	localparam logic [ST_W-1:0] ST_BAD = 3'd1;
	localparam logic [ST_W-1:0] ST_NOSPACE = 3'd2;
	localparam logic [ST_W-1:0] ST_RANGE = 3'd3;
	localparam logic [ST_W-1:0] ST_NOTUSED = 3'd4;

	localparam logic [3:0] CMD_NOP = 4'd0;
	localparam logic [3:0] CMD_LOAD = 4'd1;
	localparam logic [3:0] CMD_DIV_NEED = 4'd2;
	localparam logic [3:0] CMD_DIV_ID = 4'd3;
	localparam logic [3:0] CMD_SET_ID = 4'd4;
	localparam logic [3:0] CMD_SET_NEED = 4'd5;
	localparam logic [3:0] CMD_POP_ALLOC = 4'd6;
	localparam logic [3:0] CMD_POP_GROW = 4'd7;
	localparam logic [3:0] CMD_POP_STEP = 4'd8;
	localparam logic [3:0] CMD_REL_ID = 4'd9;
	localparam logic [3:0] CMD_REL_ISSUE = 4'd10;
	localparam logic [3:0] CMD_REL_STEP = 4'd11;
	localparam logic [3:0] CMD_WALK_INIT = 4'd12;
	localparam logic [3:0] CMD_WALK_STEP = 4'd13;
	localparam logic [3:0] CMD_CUT_INIT = 4'd14;
	localparam logic [3:0] CMD_CUT_STEP = 4'd15;

	typedef struct packed {
		logic [3:0] code;
		logic ld_st;
		logic [ST_W-1:0] st;
		logic set_roff;
		logic alloc_fin;
		logic ld_out;
	} cbpa_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic size_zero;
		logic size_big;
		logic ptr_null;
		logic ptr_out;
		logic in_use;
		logic div_busy;
		logic need_fits;
		logic need_le_have;
		logic grow_fits;
		logic pop_busy;
		logic rel_ok;
		logic rel_more;
		logic walk_more;
		logic cut_more;
	} cbpa_stat_t;

endpackage
`default_nettype wire

/* rtl/chained_block_pool_allocator.sv */
// bad fields end at the check state; failed in-use and space checks come after a division
// allocate checks space and pops its chain; free locates the block and releases its chain
// resize to zero frees the chain; other resizes walk it, then trim or extend it at one block per cycle
// block size not a power of two: each division is a repeated subtraction of the block size
// throughput: one item at a time, next item accepted the cycle after its result is registered
// reset: asynchronous, all blocks free, stack in id order, counters zero, no clearing pass
`default_nettype none
module chained_block_pool_allocator import cbpa_pkg::*; #(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [OP_W-1:0] operation,
	input wire logic [SIZE_W-1:0] request_size,
	input wire logic pointer_null,
	input wire logic [OFF_W-1:0] pointer_offset,
	output logic out_valid,
	input wire logic out_ready,
	output logic [ST_W-1:0] status,
	output logic [ROFF_W-1:0] result_offset,
	output logic [CNT_W-1:0] allocations_total,
	output logic [CNT_W-1:0] blocks_freed_total,
	output logic [FREE_W-1:0] free_count
);

	cbpa_cmd_t cmd;
	cbpa_stat_t stat;

	cbpa_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat(stat),
		.cmd(cmd)
	);

	cbpa_dpath #(.NUM_BLOCKS(NUM_BLOCKS)) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.operation(operation),
		.request_size(request_size),
		.pointer_null(pointer_null),
		.pointer_offset(pointer_offset),
		.cmd(cmd),
		.stat(stat),
		.status(status),
		.result_offset(result_offset),
		.allocations_total(allocations_total),
		.blocks_freed_total(blocks_freed_total),
		.free_count(free_count)
	);

endmodule
`default_nettype wire

/* rtl/cbpa_div.sv */
`default_nettype none
module cbpa_div import cbpa_pkg::*; #(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [VAL_W-1:0] value,
	output logic [$clog2(NUM_BLOCKS+2)-1:0] q,
	output logic busy
);

	localparam int QW = $clog2(NUM_BLOCKS + 2);
	localparam int SAT = NUM_BLOCKS + 1;
	localparam bit POW2 = (BLOCK_BYTES & (BLOCK_BYTES - 1)) == 0;
	localparam int SH = $clog2(BLOCK_BYTES);

	logic [VAL_W-1:0] rem_q;
	logic [QW-1:0] q_q;
	logic busy_q;
	logic [VAL_W-1:0] shifted;

	assign shifted = value >> SH;
	assign q = q_q;
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= !POW2;
		end else if (busy_q) begin
			if (!(rem_q >= VAL_W'(BLOCK_BYTES) && 32'(q_q) != SAT)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// quotient saturates one past the pool size
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= value;
			if (POW2) begin
				q_q <= (32'(shifted) > SAT) ? QW'(SAT) : QW'(shifted);
			end else begin
				q_q <= '0;
			end
		end else if (busy_q && rem_q >= VAL_W'(BLOCK_BYTES) && 32'(q_q) != SAT) begin
			rem_q <= rem_q - VAL_W'(BLOCK_BYTES);
			q_q <= q_q + QW'(1);
		end
	end

endmodule
`default_nettype wire

/* rtl/cbpa_dpath.sv */
`default_nettype none
module cbpa_dpath import cbpa_pkg::*; #(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [OP_W-1:0] operation,
	input wire logic [SIZE_W-1:0] request_size,
	input wire logic pointer_null,
	input wire logic [OFF_W-1:0] pointer_offset,
	input wire cbpa_cmd_t cmd,
	output cbpa_stat_t stat,
	output logic [ST_W-1:0] status,
	output logic [ROFF_W-1:0] result_offset,
	output logic [CNT_W-1:0] allocations_total,
	output logic [CNT_W-1:0] blocks_freed_total,
	output logic [FREE_W-1:0] free_count
);

	localparam int IDW = $clog2(NUM_BLOCKS + 1);
	localparam int AW = $clog2(NUM_BLOCKS);
	localparam int QW = $clog2(NUM_BLOCKS + 2);
	localparam int PW = IDW + 13;
	localparam int POOL = NUM_BLOCKS * BLOCK_BYTES;

	function automatic logic id_ok(input logic [IDW-1:0] x);
		return x != '0 && 32'(x) <= NUM_BLOCKS;
	endfunction

	function automatic logic [AW-1:0] idx(input logic [IDW-1:0] x);
		logic [IDW-1:0] t;
		t = x - IDW'(1);
		return t[AW-1:0];
	endfunction

	function automatic logic [ROFF_W-1:0] roff_of(input logic [IDW-1:0] x);
		logic [PW-1:0] p;
		p = PW'(x - IDW'(1)) * PW'(BLOCK_BYTES);
		return p[ROFF_W-1:0];
	endfunction

	logic [OP_W-1:0] op_q;
	logic [SIZE_W-1:0] size_q;
	logic pnull_q;
	logic [OFF_W-1:0] poff_q;

	logic [IDW-1:0] depth_q;
	logic [CNT_W-1:0] alloc_q, freed_q;
	logic [NUM_BLOCKS-1:0] in_use_q;

	logic [IDW-1:0] id_q, last_q, cur_q, prev_q, first_q, ci_q;
	logic [IDW-1:0] have_q, steps_q;
	logic [QW-1:0] need_q, cnt_q, b_q;
	logic pend_q, first_pend_q;
	logic [ST_W-1:0] st_q;
	logic [ROFF_W-1:0] roff_q;

	// link memory, entries never written read as end of chain
	logic [IDW-1:0] link_mem [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0] link_vld_q;
	logic [IDW-1:0] link_rd_q;
	logic link_rv_q;
	logic [IDW-1:0] lrdata;
	logic lw_en;
	logic [AW-1:0] lw_addr, lr_addr;
	logic [IDW-1:0] lw_data;

	// free stack, entries never written read as their index plus one
	logic [IDW-1:0] stk_mem [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0] stk_vld_q;
	logic [IDW-1:0] stk_rd_q;
	logic stk_rv_q;
	logic [AW-1:0] stk_ra_q, sr_addr;
	logic [IDW-1:0] srdata;
	logic push, pop_issue;

	logic div_start;
	logic [VAL_W-1:0] div_val;
	logic [QW-1:0] div_q;
	logic div_busy;

	cbpa_div #(.NUM_BLOCKS(NUM_BLOCKS)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.value(div_val),
		.q(div_q),
		.busy(div_busy)
	);

	assign div_start = cmd.code == CMD_DIV_NEED || cmd.code == CMD_DIV_ID;
	assign div_val = (cmd.code == CMD_DIV_NEED) ?
		VAL_W'(size_q) + VAL_W'(BLOCK_BYTES - 1) : VAL_W'(poff_q);

	assign lrdata = link_rv_q ? link_rd_q : '0;
	assign srdata = stk_rv_q ? stk_rd_q : IDW'(stk_ra_q) + IDW'(1);
	assign sr_addr = AW'(depth_q - IDW'(1));
	assign pop_issue = cmd.code == CMD_POP_STEP && cnt_q != '0;

	always_comb begin
		stat.op = op_q;
		stat.size_zero = size_q == '0;
		stat.size_big = 32'(size_q) > MAX_REQUEST;
		stat.ptr_null = pnull_q;
		stat.ptr_out = 32'(poff_q) >= POOL;
		stat.in_use = in_use_q[idx(id_q)];
		stat.div_busy = div_busy;
		stat.need_fits = 32'(need_q) <= 32'(depth_q);
		stat.need_le_have = 32'(need_q) <= 32'(have_q);
		stat.grow_fits = 32'(depth_q) >= 32'(need_q) - 32'(have_q);
		stat.pop_busy = pend_q || cnt_q != '0;
		stat.rel_ok = id_ok(cur_q) && 32'(steps_q) < NUM_BLOCKS;
		stat.rel_more = id_ok(lrdata) && 32'(steps_q) + 1 < NUM_BLOCKS;
		stat.walk_more = id_ok(lrdata) && 32'(have_q) < NUM_BLOCKS;
		stat.cut_more = b_q < need_q;
	end

	always_comb begin
		lw_en = 1'b0;
		lw_addr = '0;
		lw_data = '0;
		lr_addr = '0;
		push = 1'b0;
		case (cmd.code)
			CMD_POP_STEP: begin
				if (pend_q && !first_pend_q) begin
					lw_en = 1'b1;
					lw_addr = idx(prev_q);
					lw_data = srdata;
				end else if (!pend_q && cnt_q == '0) begin
					// terminate the chain
					lw_en = 1'b1;
					lw_addr = idx(prev_q);
				end
			end
			CMD_REL_ISSUE: lr_addr = idx(cur_q);
			CMD_REL_STEP: begin
				lr_addr = idx(lrdata);
				push = 32'(depth_q) < NUM_BLOCKS;
				if (push) begin
					lw_en = 1'b1;
					lw_addr = idx(cur_q);
				end
			end
			CMD_WALK_INIT, CMD_CUT_INIT: lr_addr = idx(id_q);
			CMD_WALK_STEP: lr_addr = idx(lrdata);
			CMD_CUT_STEP: begin
				lr_addr = idx(lrdata);
				if (!stat.cut_more) begin
					lw_en = 1'b1;
					lw_addr = idx(ci_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (lw_en) begin
			link_mem[lw_addr] <= lw_data;
		end
		link_rd_q <= link_mem[lr_addr];
		if (push) begin
			stk_mem[AW'(depth_q)] <= cur_q;
		end
		stk_rd_q <= stk_mem[sr_addr];
		stk_ra_q <= sr_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= IDW'(NUM_BLOCKS);
			alloc_q <= '0;
			freed_q <= '0;
			in_use_q <= '0;
			link_vld_q <= '0;
			link_rv_q <= 1'b0;
			stk_vld_q <= '0;
			stk_rv_q <= 1'b0;
			pend_q <= 1'b0;
			first_pend_q <= 1'b0;
		end else begin
			link_rv_q <= link_vld_q[lr_addr];
			stk_rv_q <= stk_vld_q[sr_addr];
			if (lw_en) begin
				link_vld_q[lw_addr] <= 1'b1;
			end
			if (push) begin
				stk_vld_q[AW'(depth_q)] <= 1'b1;
				in_use_q[idx(cur_q)] <= 1'b0;
				freed_q <= freed_q + CNT_W'(1);
				depth_q <= depth_q + IDW'(1);
			end else if (pop_issue) begin
				depth_q <= depth_q - IDW'(1);
			end
			if (cmd.alloc_fin) begin
				in_use_q[idx(first_q)] <= 1'b1;
				alloc_q <= alloc_q + CNT_W'(1);
			end
			case (cmd.code)
				CMD_POP_ALLOC: begin
					pend_q <= 1'b0;
					first_pend_q <= 1'b1;
				end
				CMD_POP_GROW: begin
					pend_q <= 1'b0;
					first_pend_q <= 1'b0;
				end
				CMD_POP_STEP: begin
					pend_q <= pop_issue;
					if (pend_q) begin
						first_pend_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.code)
			CMD_LOAD: begin
				op_q <= operation;
				size_q <= request_size;
				pnull_q <= pointer_null;
				poff_q <= pointer_offset;
				roff_q <= '0;
			end
			CMD_SET_ID: id_q <= IDW'(div_q) + IDW'(1);
			CMD_SET_NEED: need_q <= div_q;
			CMD_POP_ALLOC: cnt_q <= need_q;
			CMD_POP_GROW: begin
				cnt_q <= need_q - QW'(have_q);
				prev_q <= last_q;
			end
			CMD_POP_STEP: begin
				if (pend_q) begin
					prev_q <= srdata;
					if (first_pend_q) begin
						first_q <= srdata;
					end
				end
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - QW'(1);
				end
			end
			CMD_REL_ID: begin
				cur_q <= id_q;
				steps_q <= '0;
			end
			CMD_REL_STEP: begin
				cur_q <= lrdata;
				steps_q <= steps_q + IDW'(1);
			end
			CMD_WALK_INIT: begin
				have_q <= IDW'(1);
				last_q <= id_q;
			end
			CMD_WALK_STEP: begin
				if (stat.walk_more) begin
					have_q <= have_q + IDW'(1);
					last_q <= lrdata;
				end
			end
			CMD_CUT_INIT: begin
				ci_q <= id_q;
				b_q <= QW'(1);
			end
			CMD_CUT_STEP: begin
				if (stat.cut_more) begin
					ci_q <= lrdata;
					b_q <= b_q + QW'(1);
				end else begin
					// the cut-off tail goes back to the stack
					cur_q <= lrdata;
					steps_q <= '0;
				end
			end
			default: begin
			end
		endcase
		if (cmd.set_roff) begin
			roff_q <= roff_of(id_q);
		end
		if (cmd.alloc_fin) begin
			roff_q <= roff_of(first_q);
		end
		if (cmd.ld_st) begin
			st_q <= cmd.st;
		end
		if (cmd.ld_out) begin
			status <= st_q;
			result_offset <= roff_q;
			allocations_total <= alloc_q;
			blocks_freed_total <= freed_q;
			free_count <= FREE_W'(depth_q);
		end
	end

endmodule
`default_nettype wire

/* rtl/cbpa_ctrl.sv */
`default_nettype none
module cbpa_ctrl import cbpa_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	input wire cbpa_stat_t stat,
	output cbpa_cmd_t cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_ANEED = 4'd2;
	localparam logic [3:0] S_ACHK = 4'd3;
	localparam logic [3:0] S_POP = 4'd4;
	localparam logic [3:0] S_LOCDIV = 4'd5;
	localparam logic [3:0] S_LOC = 4'd6;
	localparam logic [3:0] S_REL0 = 4'd7;
	localparam logic [3:0] S_REL1 = 4'd8;
	localparam logic [3:0] S_RNEED = 4'd9;
	localparam logic [3:0] S_WALK0 = 4'd10;
	localparam logic [3:0] S_WALK1 = 4'd11;
	localparam logic [3:0] S_RDEC = 4'd12;
	localparam logic [3:0] S_CUT = 4'd13;
	localparam logic [3:0] S_DONE = 4'd14;

	logic [3:0] state_q, state_d;
	logic out_valid_q;

	assign in_ready = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.code = CMD_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = S_DONE;
				cmd.ld_st = 1'b1;
				cmd.st = ST_BAD;
				if (stat.op == OP_ALLOC) begin
					if (!stat.size_zero && !stat.size_big) begin
						cmd.ld_st = 1'b0;
						cmd.code = CMD_DIV_NEED;
						state_d = S_ANEED;
					end
				end else if (stat.op == OP_FREE || stat.op == OP_RESIZE) begin
					if (stat.ptr_null ||
					    (stat.op == OP_RESIZE && !stat.size_zero && stat.size_big)) begin
						cmd.st = ST_BAD;
					end else if (stat.ptr_out) begin
						cmd.st = ST_RANGE;
					end else begin
						cmd.ld_st = 1'b0;
						cmd.code = CMD_DIV_ID;
						state_d = S_LOCDIV;
					end
				end
			end
			S_ANEED: begin
				if (!stat.div_busy) begin
					cmd.code = CMD_SET_NEED;
					state_d = S_ACHK;
				end
			end
			S_ACHK: begin
				if (stat.need_fits) begin
					cmd.code = CMD_POP_ALLOC;
					state_d = S_POP;
				end else begin
					cmd.ld_st = 1'b1;
					cmd.st = ST_NOSPACE;
					state_d = S_DONE;
				end
			end
			S_POP: begin
				cmd.code = CMD_POP_STEP;
				if (!stat.pop_busy) begin
					cmd.ld_st = 1'b1;
					cmd.st = ST_OK;
					cmd.alloc_fin = stat.op == OP_ALLOC;
					state_d = S_DONE;
				end
			end
			S_LOCDIV: begin
				if (!stat.div_busy) begin
					cmd.code = CMD_SET_ID;
					state_d = S_LOC;
				end
			end
			S_LOC: begin
				if (!stat.in_use) begin
					cmd.ld_st = 1'b1;
					cmd.st = ST_NOTUSED;
					state_d = S_DONE;
				end else if (stat.op == OP_FREE || stat.size_zero) begin
					cmd.code = CMD_REL_ID;
					state_d = S_REL0;
				end else begin
					cmd.code = CMD_DIV_NEED;
					state_d = S_RNEED;
				end
			end
			S_REL0: begin
				if (stat.rel_ok) begin
					cmd.code = CMD_REL_ISSUE;
					state_d = S_REL1;
				end else begin
					cmd.ld_st = 1'b1;
					cmd.st = ST_OK;
					state_d = S_DONE;
				end
			end
			S_REL1: begin
				cmd.code = CMD_REL_STEP;
				if (!stat.rel_more) begin
					cmd.ld_st = 1'b1;
					cmd.st = ST_OK;
					state_d = S_DONE;
				end
			end
			S_RNEED: begin
				if (!stat.div_busy) begin
					cmd.code = CMD_SET_NEED;
					state_d = S_WALK0;
				end
			end
			S_WALK0: begin
				cmd.code = CMD_WALK_INIT;
				state_d = S_WALK1;
			end
			S_WALK1: begin
				cmd.code = CMD_WALK_STEP;
				if (!stat.walk_more) begin
					state_d = S_RDEC;
				end
			end
			S_RDEC: begin
				if (stat.need_le_have) begin
					cmd.code = CMD_CUT_INIT;
					cmd.set_roff = 1'b1;
					state_d = S_CUT;
				end else if (stat.grow_fits) begin
					cmd.code = CMD_POP_GROW;
					cmd.set_roff = 1'b1;
					state_d = S_POP;
				end else begin
					cmd.ld_st = 1'b1;
					cmd.st = ST_NOSPACE;
					state_d = S_DONE;
				end
			end
			S_CUT: begin
				cmd.code = CMD_CUT_STEP;
				if (!stat.cut_more) begin
					state_d = S_REL0;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.ld_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb import cbpa_pkg::*; ();

	localparam int NB = NUM_BLOCKS_DEF;
	localparam int POOL_BYTES = NB * BLOCK_BYTES;
	localparam int WATCHDOG = 20000;
	localparam int N_RANDOM = 1630;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [OP_W-1:0] operation = OP_ALLOC;
	logic [SIZE_W-1:0] request_size = '0;
	logic pointer_null = 1'b0;
	logic [OFF_W-1:0] pointer_offset = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ST_W-1:0] status;
	logic [ROFF_W-1:0] result_offset;
	logic [CNT_W-1:0] allocations_total;
	logic [CNT_W-1:0] blocks_freed_total;
	logic [FREE_W-1:0] free_count;

	chained_block_pool_allocator dut (.*);

	always #2 clk = ~clk;

	typedef struct packed {
		logic [ST_W-1:0] st;
		logic [ROFF_W-1:0] roff;
		logic [CNT_W-1:0] allocs;
		logic [CNT_W-1:0] freed;
		logic [FREE_W-1:0] nfree;
	} reply_t;

	typedef struct {
		logic [OP_W-1:0] op;
		int size;
		logic pnull;
		int poff;
		bit has_fixed;
		logic [ST_W-1:0] fixed_st;
	} stim_t;

	// shadow of the pool
	int stack_ids[NB];
	int depth;
	bit in_use[NB];
	int req_size[NB];
	int link_of[NB];
	logic [CNT_W-1:0] n_allocs, n_freed;
	int live_offs[$];

	reply_t pending_replies[$];
	int n_errors = 0;
	int idle_cycles = 0;
	bit quiet_mode = 1'b0;
	bit hold_recv = 1'b0;
	bit stim_done = 1'b0;

	function automatic bit id_ok(int id);
		return id >= 1 && id <= NB;
	endfunction

	function automatic int pop_id();
		if (depth == 0) return 0;
		depth--;
		return stack_ids[depth];
	endfunction

	function automatic void push_id(int id);
		if (!id_ok(id) || depth >= NB) return;
		in_use[id-1] = 0;
		req_size[id-1] = 0;
		link_of[id-1] = 0;
		stack_ids[depth] = id;
		depth++;
		n_freed++;
	endfunction

	function automatic void release_chain(int id);
		int steps, nxt;
		steps = 0;
		while (id_ok(id) && steps < NB) begin
			nxt = link_of[id-1];
			push_id(id);
			id = nxt;
			steps++;
		end
	endfunction

	function automatic int locate(logic pnull, int off, output int id);
		id = 0;
		if (pnull) return ST_BAD;
		if (off >= POOL_BYTES) return ST_RANGE;
		id = off / BLOCK_BYTES + 1;
		if (!in_use[id-1]) return ST_NOTUSED;
		return ST_OK;
	endfunction

	function automatic void pool_reset();
		for (int i = 0; i < NB; i++) begin
			stack_ids[i] = i + 1;
			in_use[i] = 0;
			req_size[i] = 0;
			link_of[i] = 0;
		end
		depth = NB;
		n_allocs = '0;
		n_freed = '0;
	endfunction

	function automatic reply_t predict_pool(logic [OP_W-1:0] op, int size, logic pnull, int poff);
		reply_t r;
		int st, roff, id, need, first, prev, nxt, have, last, cur, ci, rest;
		st = ST_BAD;
		roff = 0;
		id = 0;
		need = (size + BLOCK_BYTES - 1) / BLOCK_BYTES;
		if (op == OP_ALLOC) begin
			if (size != 0 && size <= MAX_REQUEST) begin
				if (depth < need) st = ST_NOSPACE;
				else begin
					first = pop_id();
					prev = first;
					for (int i = 1; i < need; i++) begin
						nxt = pop_id();
						link_of[prev-1] = nxt;
						prev = nxt;
					end
					link_of[prev-1] = 0;
					in_use[first-1] = 1;
					req_size[first-1] = size;
					n_allocs++;
					st = ST_OK;
					roff = (first - 1) * BLOCK_BYTES;
				end
			end
		end else if (op == OP_FREE || (op == OP_RESIZE && size == 0)) begin
			st = locate(pnull, poff, id);
			if (st == ST_OK) release_chain(id);
		end else if (op == OP_RESIZE) begin
			if (pnull || size > MAX_REQUEST) st = ST_BAD;
			else st = locate(pnull, poff, id);
			if (st == ST_OK) begin
				have = 0;
				last = id;
				cur = id;
				while (id_ok(cur) && have < NB) begin
					have++;
					last = cur;
					cur = link_of[cur-1];
				end
				if (need <= have) begin
					ci = id;
					for (int b = 1; b < need; b++) ci = link_of[ci-1];
					rest = link_of[ci-1];
					link_of[ci-1] = 0;
					release_chain(rest);
					req_size[id-1] = size;
				end else if (depth >= need - have) begin
					prev = last;
					for (int i = 0; i < need - have; i++) begin
						nxt = pop_id();
						link_of[prev-1] = nxt;
						prev = nxt;
					end
					link_of[prev-1] = 0;
					req_size[id-1] = size;
				end else st = ST_NOSPACE;
				if (st == ST_OK) roff = (id - 1) * BLOCK_BYTES;
			end
		end
		r.st = st[ST_W-1:0];
		r.roff = roff[ROFF_W-1:0];
		r.allocs = n_allocs;
		r.freed = n_freed;
		r.nfree = depth[FREE_W-1:0];
		return r;
	endfunction

	// drive one item and record what the pool should answer
	task automatic send_item(stim_t s);
		reply_t r;
		if (!quiet_mode && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= s.op;
		request_size <= s.size[SIZE_W-1:0];
		pointer_null <= s.pnull;
		pointer_offset <= s.poff[OFF_W-1:0];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		r = predict_pool(s.op, s.size, s.pnull, s.poff);
		if (s.has_fixed && r.st != s.fixed_st) begin
			n_errors++;
			if (n_errors <= 10)
				$display("directed row status disagrees: table %0d predicted %0d",
					s.fixed_st, r.st);
		end
		pending_replies.push_back(r);
		if (s.op == OP_ALLOC && r.st == ST_OK) live_offs.push_back(int'(r.roff));
		@(negedge clk);
	endtask

	function automatic stim_t mk(logic [OP_W-1:0] op, int size, logic pnull, int poff,
			bit fx = 0, logic [ST_W-1:0] fst = ST_OK);
		stim_t s;
		s.op = op;
		s.size = size;
		s.pnull = pnull;
		s.poff = poff;
		s.has_fixed = fx;
		s.fixed_st = fst;
		return s;
	endfunction

	function automatic int pick_ptr();
		int k;
		if (live_offs.size() == 0 || $urandom_range(9) == 0) return $urandom_range(POOL_BYTES - 1);
		k = $urandom_range(live_offs.size() - 1);
		return live_offs[k] + (($urandom_range(3) == 0) ? $urandom_range(BLOCK_BYTES - 1) : 0);
	endfunction

	function automatic int pick_size();
		case ($urandom_range(9))
			0: return $urandom_range(8191);
			1: return $urandom_range(MAX_REQUEST);
			2: return 0;
			default: return $urandom_range(1, 400);
		endcase
	endfunction

	stim_t table_rows[$];

	initial begin
		stim_t s;
		int p;
		pool_reset();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		table_rows.push_back(mk(OP_FREE, 0, 1'b1, 0, 1, ST_BAD));
		table_rows.push_back(mk(OP_FREE, 0, 1'b0, 8191, 1, ST_RANGE));
		table_rows.push_back(mk(OP_FREE, 0, 1'b0, POOL_BYTES, 1, ST_RANGE));
		table_rows.push_back(mk(OP_FREE, 0, 1'b0, 0, 1, ST_NOTUSED));
		table_rows.push_back(mk(OP_RESIZE, 10, 1'b0, 0, 1, ST_NOTUSED));
		table_rows.push_back(mk(OP_RESIZE, 10, 1'b1, 0, 1, ST_BAD));
		table_rows.push_back(mk(OP_RESIZE, 8191, 1'b0, 0, 1, ST_BAD));
		table_rows.push_back(mk(OP_ALLOC, 0, 1'b1, 8191, 1, ST_BAD));
		table_rows.push_back(mk(OP_ALLOC, 8191, 1'b0, 0, 1, ST_BAD));
		table_rows.push_back(mk(OP_ALLOC, MAX_REQUEST + 1, 1'b0, 0, 1, ST_BAD));
		table_rows.push_back(mk(2'd3, 100, 1'b0, 0, 1, ST_BAD));
		table_rows.push_back(mk(OP_ALLOC, MAX_REQUEST, 1'b0, 0, 1, ST_OK));
		table_rows.push_back(mk(OP_ALLOC, 1, 1'b0, 0, 1, ST_NOSPACE));
		table_rows.push_back(mk(OP_RESIZE, 100, 1'b0, 0));
		table_rows.push_back(mk(OP_RESIZE, 0, 1'b0, 63));
		table_rows.push_back(mk(OP_FREE, 0, 1'b0, 0, 1, ST_NOTUSED));
		table_rows.push_back(mk(OP_ALLOC, 65, 1'b0, 0));
		table_rows.push_back(mk(OP_ALLOC, 1, 1'b0, 0));
		table_rows.push_back(mk(OP_RESIZE, 64 * 30, 1'b0, 0));
		table_rows.push_back(mk(OP_RESIZE, 64 * 60, 1'b0, 0));
		table_rows.push_back(mk(OP_FREE, 0, 1'b0, 64 * 63));
		table_rows.push_back(mk(OP_FREE, 0, 1'b0, 4095));
		foreach (table_rows[i]) begin
			s = table_rows[i];
			// offsets of rows after the first allocations follow the shadow
			if (i >= 13 && i <= 15 || i >= 18 && i <= 19) begin
				p = (live_offs.size() > 0) ? live_offs[0] : 0;
				s.poff = p + ((s.op == OP_RESIZE && s.size == 0) ? 63 : 0);
			end
			send_item(s);
		end
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 300) begin
				in_valid <= 1'b0;
				do @(negedge clk); while (pending_replies.size() != 0);
			end
			quiet_mode = (n >= 600 && n < 800);
			hold_recv = (n >= 900 && n < 910);
			case ($urandom_range(9))
				0, 1, 2, 3: s = mk(OP_ALLOC, pick_size(), 1'($urandom_range(1)),
					$urandom_range(8191));
				4, 5, 6: s = mk(OP_FREE, pick_size(), $urandom_range(19) == 0, pick_ptr());
				7, 8: s = mk(OP_RESIZE, pick_size(), $urandom_range(19) == 0, pick_ptr());
				default: s = mk(OP_W'($urandom_range(3)), $urandom_range(8191),
					1'($urandom_range(1)), $urandom_range(8191));
			endcase
			send_item(s);
		end
		in_valid <= 1'b0;
		hold_recv = 0;
		stim_done = 1'b1;
	end

	// receiver side
	initial begin
		forever begin
			@(negedge clk);
			if (hold_recv) begin
				out_ready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_recv = 0;
			end else out_ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 26);
		end
	end

	always @(posedge clk) begin
		reply_t want, got;
		if (arst_n && out_valid && out_ready) begin
			got = '{status, result_offset, allocations_total, blocks_freed_total, free_count};
			if (pending_replies.size() == 0) begin
				n_errors++;
				if (n_errors <= 10) $display("item result with nothing pending: %p", got);
			end else begin
				want = pending_replies.pop_front();
				if (got != want) begin
					n_errors++;
					if (n_errors <= 10) $display("mismatch: expected %p got %p", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (stim_done);
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (n_errors == 0 && pending_replies.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire
